>>> rtl/core/hsv_hsl_color_converter_top_defines.svh
// Assertion macros shared by the color converter checkers.
// Depends on aclk and aresetn being visible where the macros are used.
`ifndef HSV_HSL_COLOR_CONVERTER_TOP_DEFINES_SVH
`define HSV_HSL_COLOR_CONVERTER_TOP_DEFINES_SVH

// same-cycle implication, masked during reset
`define HHC_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("hhc assertion failed");

// next-cycle implication, masked during reset
`define HHC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("hhc assertion failed");

// next-cycle implication that also holds across reset
`define HHC_ASSERT_NEXT_RST(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("hhc assertion failed");

`endif

>>> rtl/core/hhc_pkg.sv
// Shared types and constants for the HSV/HSL color converter.
// No dependencies.
package hhc_pkg;

    localparam int FIELD_W = 16;

    typedef enum logic [1:0] {
        MODE_RGB2HSV = 2'd0,
        MODE_HSV2RGB = 2'd1,
        MODE_RGB2HSL = 2'd2,
        MODE_HSL2RGB = 2'd3
    } conv_mode_t;

endpackage

>>> rtl/core/hhc_front.sv
// Front end: input register, max/min/chroma analysis, divider operand build.
// Depends on hhc_pkg.
module hhc_front #(
    parameter int CHANNEL_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  hhc_pkg::conv_mode_t         mode,
    input  logic [hhc_pkg::FIELD_W-1:0] in_c0,
    input  logic [hhc_pkg::FIELD_W-1:0] in_c1,
    input  logic [hhc_pkg::FIELD_W-1:0] in_c2,
    input  logic [hhc_pkg::FIELD_W-1:0] in_alpha,
    output logic                        out_valid,
    output logic [2*CHANNEL_BITS+2:0]   dividend_a,
    output logic [CHANNEL_BITS+2:0]     divisor_a,
    output logic [2*CHANNEL_BITS+2:0]   dividend_b,
    output logic [CHANNEL_BITS+2:0]     divisor_b,
    output logic [4*CHANNEL_BITS+4:0]   side
);
    import hhc_pkg::*;

    localparam int N  = CHANNEL_BITS;
    localparam int DW = 2 * N + 3;
    localparam int VW = N + 3;
    localparam logic [N-1:0] FS = {N{1'b1}};
    localparam logic [N:0]   TWO_FS = {FS, 1'b0};

    // stage 1: input register
    logic             v1_reg;
    conv_mode_t       mode1_reg;
    logic [N-1:0]     c0_1_reg, c1_1_reg, c2_1_reg, a1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mode1_reg <= mode;
            c0_1_reg  <= N'(in_c0);
            c1_1_reg  <= N'(in_c1);
            c2_1_reg  <= N'(in_c2);
            a1_reg    <= N'(in_alpha);
        end
    end

    // stage 1 logic: max, min, chroma, hue numerator, denominators
    logic                max_r, max_g;
    logic [N-1:0]        mx, mn, chroma, den, base, cap, divb;
    logic signed [N+3:0] num_s, six_c;
    logic [N:0]          sum, l2, lvl;

    always_comb begin
        max_r = (c0_1_reg >= c1_1_reg) && (c0_1_reg >= c2_1_reg);
        max_g = !max_r && (c1_1_reg >= c2_1_reg);
        mx = max_r ? c0_1_reg : (max_g ? c1_1_reg : c2_1_reg);
        mn = (c0_1_reg <= c1_1_reg) ? c0_1_reg : c1_1_reg;
        if (c2_1_reg < mn) begin
            mn = c2_1_reg;
        end
        chroma = mx - mn;
        // 6*C as 4*C + 2*C
        six_c = $signed({2'b0, chroma, 2'b0}) + $signed({3'b0, chroma, 1'b0});
        if (max_r) begin
            num_s = $signed({4'b0, c1_1_reg}) - $signed({4'b0, c2_1_reg});
        end else if (max_g) begin
            num_s = $signed({3'b0, chroma, 1'b0}) + $signed({4'b0, c2_1_reg})
                    - $signed({4'b0, c0_1_reg});
        end else begin
            num_s = $signed({2'b0, chroma, 2'b0}) + $signed({4'b0, c0_1_reg})
                    - $signed({4'b0, c1_1_reg});
        end
        if (num_s < 0) begin
            num_s = num_s + six_c;
        end
        sum  = {1'b0, mx} + {1'b0, mn};
        den  = (sum <= {1'b0, FS}) ? N'(sum) : N'(TWO_FS - sum);
        l2   = {c2_1_reg, 1'b0};
        base = (l2 <= {1'b0, FS}) ? N'(l2) : N'(TWO_FS - l2);
        case (mode1_reg)
            MODE_RGB2HSV: lvl = {1'b0, mx};
            MODE_RGB2HSL: lvl = sum;
            MODE_HSV2RGB: lvl = {1'b0, c2_1_reg};
            default:      lvl = l2;
        endcase
        cap  = (mode1_reg == MODE_HSV2RGB) ? c2_1_reg : base;
        divb = (mode1_reg == MODE_RGB2HSV) ? mx : den;
    end

    // stage 2 register
    logic             v2_reg, zc2_reg, zm2_reg;
    conv_mode_t       mode2_reg;
    logic [N-1:0]     a2_reg, hue2_reg, sat2_reg, cap2_reg, chroma2_reg, divb2_reg;
    logic [N:0]       lvl2_reg;
    logic [N+2:0]     num2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mode2_reg   <= mode1_reg;
            a2_reg      <= a1_reg;
            hue2_reg    <= c0_1_reg;
            sat2_reg    <= c1_1_reg;
            cap2_reg    <= cap;
            chroma2_reg <= chroma;
            divb2_reg   <= divb;
            lvl2_reg    <= lvl;
            num2_reg    <= num_s[N+2:0];
            zc2_reg     <= (chroma == '0);
            zm2_reg     <= (mx == '0);
        end
    end

    // stage 2 logic: dividends and divisors
    logic             rgb2;
    logic [2*N-1:0]   prod;
    logic [DW-1:0]    dva, dvb;
    logic [VW-1:0]    dsa, dsb;

    always_comb begin
        rgb2 = (mode2_reg == MODE_RGB2HSV) || (mode2_reg == MODE_RGB2HSL);
        prod = cap2_reg * sat2_reg;
        dva  = rgb2 ? {num2_reg, {N{1'b0}}} : DW'(prod);
        dsa  = rgb2 ? (VW'({chroma2_reg, 2'b0}) + VW'({chroma2_reg, 1'b0})) : VW'(FS);
        dvb  = DW'({chroma2_reg, {N{1'b0}}}) - DW'(chroma2_reg);
        dsb  = VW'(divb2_reg);
    end

    // stage 3 register: divider operands
    logic             v3_reg;
    logic [DW-1:0]    dva_reg, dvb_reg;
    logic [VW-1:0]    dsa_reg, dsb_reg;
    logic [4*N+4:0]   side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dva_reg  <= dva;
            dvb_reg  <= dvb;
            dsa_reg  <= dsa;
            dsb_reg  <= dsb;
            side_reg <= {mode2_reg, zc2_reg, zm2_reg, a2_reg, hue2_reg, lvl2_reg, cap2_reg};
        end
    end

    assign out_valid  = v3_reg;
    assign dividend_a = dva_reg;
    assign dividend_b = dvb_reg;
    assign divisor_a  = dsa_reg;
    assign divisor_b  = dsb_reg;
    assign side       = side_reg;

endmodule

>>> rtl/core/hhc_div.sv
// Dual pipelined restoring divider, one quotient bit per stage, round half up.
// Depends on hhc_pkg.
module hhc_div #(
    parameter int CHANNEL_BITS = 16,
    parameter int SIDE_W       = 69
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [2*CHANNEL_BITS+2:0] dividend_a,
    input  logic [CHANNEL_BITS+2:0]   divisor_a,
    input  logic [2*CHANNEL_BITS+2:0] dividend_b,
    input  logic [CHANNEL_BITS+2:0]   divisor_b,
    input  logic [SIDE_W-1:0]         side_in,
    output logic                      out_valid,
    output logic [CHANNEL_BITS:0]     quot_a,
    output logic [CHANNEL_BITS:0]     quot_b,
    output logic [SIDE_W-1:0]         side_out
);
    import hhc_pkg::*;

    localparam int N  = CHANNEL_BITS;
    localparam int DW = 2 * N + 3;
    localparam int VW = N + 3;

    // one restoring step: {quotient bit, next remainder}
    function automatic logic [VW:0] div_step(input logic [VW-1:0] rem, input logic nb,
                                             input logic [VW-1:0] d);
        logic [VW:0] r2;
        logic        ge;
        r2 = {rem, nb};
        ge = (r2 >= {1'b0, d});
        return {ge, ge ? VW'(r2 - {1'b0, d}) : VW'(r2)};
    endfunction

    logic              v_reg    [0:N];
    logic [VW-1:0]     rem_a_reg[0:N];
    logic [VW-1:0]     rem_b_reg[0:N];
    logic [VW-1:0]     d_a_reg  [0:N];
    logic [VW-1:0]     d_b_reg  [0:N];
    logic [N-1:0]      lo_a_reg [0:N];
    logic [N-1:0]      lo_b_reg [0:N];
    logic [N-1:0]      q_a_reg  [0:N];
    logic [N-1:0]      q_b_reg  [0:N];
    logic [SIDE_W-1:0] side_reg [0:N];

    // valid bits follow the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= N; k++) begin
                v_reg[k] <= 1'b0;
            end
        end else if (en) begin
            v_reg[0] <= in_valid;
            for (int k = 0; k < N; k++) begin
                v_reg[k+1] <= v_reg[k];
            end
        end
    end

    // load stage: high part of the dividend is the first remainder
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_a_reg[0] <= dividend_a[DW-1:N];
            rem_b_reg[0] <= dividend_b[DW-1:N];
            lo_a_reg[0]  <= dividend_a[N-1:0];
            lo_b_reg[0]  <= dividend_b[N-1:0];
            d_a_reg[0]   <= divisor_a;
            d_b_reg[0]   <= divisor_b;
            q_a_reg[0]   <= '0;
            q_b_reg[0]   <= '0;
            side_reg[0]  <= side_in;
        end
    end

    // one quotient bit per stage
    for (genvar k = 0; k < N; k++) begin : g_step
        logic [VW:0] sa, sb;
        assign sa = div_step(rem_a_reg[k], lo_a_reg[k][N-1], d_a_reg[k]);
        assign sb = div_step(rem_b_reg[k], lo_b_reg[k][N-1], d_b_reg[k]);

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_a_reg[k+1] <= sa[VW-1:0];
                rem_b_reg[k+1] <= sb[VW-1:0];
                lo_a_reg[k+1]  <= lo_a_reg[k] << 1;
                lo_b_reg[k+1]  <= lo_b_reg[k] << 1;
                q_a_reg[k+1]   <= {q_a_reg[k][N-2:0], sa[VW]};
                q_b_reg[k+1]   <= {q_b_reg[k][N-2:0], sb[VW]};
                d_a_reg[k+1]   <= d_a_reg[k];
                d_b_reg[k+1]   <= d_b_reg[k];
                side_reg[k+1]  <= side_reg[k];
            end
        end
    end

    // rounding: add one when twice the remainder reaches the divisor
    logic              rnd_a, rnd_b, vo_reg;
    logic [N:0]        qa_reg, qb_reg;
    logic [SIDE_W-1:0] so_reg;

    assign rnd_a = ({rem_a_reg[N], 1'b0} >= {1'b0, d_a_reg[N]});
    assign rnd_b = ({rem_b_reg[N], 1'b0} >= {1'b0, d_b_reg[N]});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vo_reg <= 1'b0;
        end else if (en) begin
            vo_reg <= v_reg[N];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            qa_reg <= {1'b0, q_a_reg[N]} + (N+1)'(rnd_a);
            qb_reg <= {1'b0, q_b_reg[N]} + (N+1)'(rnd_b);
            so_reg <= side_reg[N];
        end
    end

    assign out_valid = vo_reg;
    assign quot_a    = qa_reg;
    assign quot_b    = qb_reg;
    assign side_out  = so_reg;

endmodule

>>> rtl/core/hhc_back.sv
// Back end: hue/saturation finish, hexagon placement, offset and clamp.
// Depends on hhc_pkg.
module hhc_back #(
    parameter int CHANNEL_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [CHANNEL_BITS:0]       quot_a,
    input  logic [CHANNEL_BITS:0]       quot_b,
    input  logic [4*CHANNEL_BITS+4:0]   side,
    output logic                        out_valid,
    output logic [hhc_pkg::FIELD_W-1:0] out_c0,
    output logic [hhc_pkg::FIELD_W-1:0] out_c1,
    output logic [hhc_pkg::FIELD_W-1:0] out_c2,
    output logic [hhc_pkg::FIELD_W-1:0] out_alpha
);
    import hhc_pkg::*;

    localparam int N = CHANNEL_BITS;
    localparam logic [N-1:0] FS   = {N{1'b1}};
    localparam logic [N:0]   TURN = {1'b1, {N{1'b0}}};

    function automatic logic [N-1:0] clamp_fs(input logic [N+2:0] v);
        return (v > (N+3)'(FS)) ? FS : v[N-1:0];
    endfunction

    // unpack side band
    conv_mode_t   mode;
    logic [1:0]   mode_bits;
    logic         zc, zm;
    logic [N-1:0] alpha, hue, cap;
    logic [N:0]   lvl;

    assign {mode_bits, zc, zm, alpha, hue, lvl, cap} = side;
    assign mode = conv_mode_t'(mode_bits);

    // stage 4 logic
    logic [N-1:0] hue_o, sat_o, val_o, cx, frac;
    logic [N+2:0] t6;
    logic [2:0]   sec;
    logic [N:0]   f;
    logic [2*N:0] prod;

    always_comb begin
        hue_o = zc ? '0 : quot_a[N-1:0];
        sat_o = ((mode == MODE_RGB2HSV) ? zm : zc) ? '0 : clamp_fs((N+3)'(quot_b));
        if (mode == MODE_RGB2HSV) begin
            val_o = lvl[N-1:0];
        end else begin
            val_o = clamp_fs(((N+3)'(lvl) + (N+3)'(1)) >> 1);
        end
        cx   = (quot_a > {1'b0, cap}) ? cap : quot_a[N-1:0];
        t6   = (N+3)'({hue, 2'b0}) + (N+3)'({hue, 1'b0});
        sec  = t6[N+2:N];
        frac = t6[N-1:0];
        f    = sec[0] ? (TURN - {1'b0, frac}) : {1'b0, frac};
        prod = cx * f;
    end

    logic             v4_reg;
    conv_mode_t       mode4_reg;
    logic [N-1:0]     a4_reg, o0_4_reg, o1_4_reg, o2_4_reg, cx4_reg;
    logic [2:0]       sec4_reg;
    logic [2*N:0]     prod4_reg;
    logic [N:0]       lvl4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mode4_reg <= mode;
            a4_reg    <= alpha;
            o0_4_reg  <= hue_o;
            o1_4_reg  <= sat_o;
            o2_4_reg  <= val_o;
            cx4_reg   <= cx;
            sec4_reg  <= sec;
            prod4_reg <= prod;
            lvl4_reg  <= lvl;
        end
    end

    // stage 5 logic: place chroma on the hexagon, add offset
    logic [2*N:0]   xs;
    logic [N-1:0]   x;
    logic [N-1:0]   comp [3];
    logic [N-1:0]   res  [3];
    logic [N+2:0]   d;

    always_comb begin
        xs = prod4_reg + (2*N+1)'(TURN >> 1);
        x  = N'(xs >> N);
        case (sec4_reg)
            3'd0:    begin comp[0] = cx4_reg; comp[1] = x;       comp[2] = '0;      end
            3'd1:    begin comp[0] = x;       comp[1] = cx4_reg; comp[2] = '0;      end
            3'd2:    begin comp[0] = '0;      comp[1] = cx4_reg; comp[2] = x;       end
            3'd3:    begin comp[0] = '0;      comp[1] = x;       comp[2] = cx4_reg; end
            3'd4:    begin comp[0] = x;       comp[1] = '0;      comp[2] = cx4_reg; end
            default: begin comp[0] = cx4_reg; comp[1] = '0;      comp[2] = x;       end
        endcase
        d = '0;
        for (int i = 0; i < 3; i++) begin
            if (mode4_reg == MODE_HSV2RGB) begin
                res[i] = clamp_fs((N+3)'(comp[i]) + (N+3)'(lvl4_reg) - (N+3)'(cx4_reg));
            end else begin
                d = (N+3)'({comp[i], 1'b0}) + (N+3)'(lvl4_reg) - (N+3)'(cx4_reg);
                res[i] = clamp_fs((d + (N+3)'(1)) >> 1);
            end
        end
    end

    // output register
    logic         vo_reg;
    logic [N-1:0] o0_reg, o1_reg, o2_reg, ao_reg;
    logic         rgb4;

    assign rgb4 = (mode4_reg == MODE_RGB2HSV) || (mode4_reg == MODE_RGB2HSL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vo_reg <= 1'b0;
        end else if (en) begin
            vo_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            o0_reg <= rgb4 ? o0_4_reg : res[0];
            o1_reg <= rgb4 ? o1_4_reg : res[1];
            o2_reg <= rgb4 ? o2_4_reg : res[2];
            ao_reg <= a4_reg;
        end
    end

    assign out_valid = vo_reg;
    assign out_c0    = FIELD_W'(o0_reg);
    assign out_c1    = FIELD_W'(o1_reg);
    assign out_c2    = FIELD_W'(o2_reg);
    assign out_alpha = FIELD_W'(ao_reg);

endmodule

>>> rtl/core/hsv_hsl_color_converter_top.sv
// Pixel color converter (RGB to/from HSV and HSL): one pixel per clock, fully pipelined.
// From acceptance to m_valid a pixel passes through CHANNEL_BITS + 7 register stages:
// three front stages, a restoring divider with a load stage, one quotient bit per stage
// and a rounding stage, and two back stages.
// All stages advance together; s_ready drops only while a finished result waits
// at the output and is not taken. Write conversion_mode through cfg_* while idle.
// Depends on hhc_pkg, hhc_front, hhc_div, hhc_back.
module hsv_hsl_color_converter_top #(
    parameter int CHANNEL_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [hhc_pkg::FIELD_W-1:0] s_in_c0,
    input  logic [hhc_pkg::FIELD_W-1:0] s_in_c1,
    input  logic [hhc_pkg::FIELD_W-1:0] s_in_c2,
    input  logic [hhc_pkg::FIELD_W-1:0] s_in_alpha,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [hhc_pkg::FIELD_W-1:0] m_out_c0,
    output logic [hhc_pkg::FIELD_W-1:0] m_out_c1,
    output logic [hhc_pkg::FIELD_W-1:0] m_out_c2,
    output logic [hhc_pkg::FIELD_W-1:0] m_out_alpha
);
    import hhc_pkg::*;

    localparam int N      = CHANNEL_BITS;
    localparam int SIDE_W = 4 * N + 5;

    // mode register
    conv_mode_t mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_RGB2HSV;
        end else if (cfg_valid) begin
            mode_reg <= conv_mode_t'(cfg_data);
        end
    end

    assign cfg_ready = 1'b1;

    // pipeline advance
    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    logic              f_valid, d_valid;
    logic [2*N+2:0]    dva, dvb;
    logic [N+2:0]      dsa, dsb;
    logic [SIDE_W-1:0] f_side, d_side;
    logic [N:0]        qa, qb;

    hhc_front #(.CHANNEL_BITS(N)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (s_valid),
        .mode       (mode_reg),
        .in_c0      (s_in_c0),
        .in_c1      (s_in_c1),
        .in_c2      (s_in_c2),
        .in_alpha   (s_in_alpha),
        .out_valid  (f_valid),
        .dividend_a (dva),
        .divisor_a  (dsa),
        .dividend_b (dvb),
        .divisor_b  (dsb),
        .side       (f_side)
    );

    hhc_div #(.CHANNEL_BITS(N), .SIDE_W(SIDE_W)) u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (f_valid),
        .dividend_a (dva),
        .divisor_a  (dsa),
        .dividend_b (dvb),
        .divisor_b  (dsb),
        .side_in    (f_side),
        .out_valid  (d_valid),
        .quot_a     (qa),
        .quot_b     (qb),
        .side_out   (d_side)
    );

    hhc_back #(.CHANNEL_BITS(N)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (d_valid),
        .quot_a    (qa),
        .quot_b    (qb),
        .side      (d_side),
        .out_valid (m_valid),
        .out_c0    (m_out_c0),
        .out_c1    (m_out_c1),
        .out_c2    (m_out_c2),
        .out_alpha (m_out_alpha)
    );

endmodule

>>> rtl/core/hhc_checker.sv
// Port-level checks for the color converter, bound to the top level.
// Depends on hhc_pkg and hsv_hsl_color_converter_top_defines.svh.
`include "hsv_hsl_color_converter_top_defines.svh"

module hhc_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [hhc_pkg::FIELD_W-1:0] m_out_alpha
);

    // pipeline never stalls while the output is empty
    `HHC_ASSERT_IMPLY(a_ready_when_empty, !m_valid, s_ready)

    // reset empties the output
    `HHC_ASSERT_NEXT_RST(a_reset_clears, !aresetn, !m_valid)

    // a stalled result request stays
    `HHC_ASSERT_NEXT(a_hold_valid, m_valid && !m_ready, m_valid)

    // and keeps its alpha
    `HHC_ASSERT_NEXT(a_hold_alpha, m_valid && !m_ready, $stable(m_out_alpha))

endmodule

bind hsv_hsl_color_converter_top hhc_checker u_hhc_checker (.*);

>>> sim/tb_top.sv
// Testbench for the HSV/HSL color converter: directed pixels in all four modes, random
// ones in random modes, checked against a bit-exact predictor in a small scoreboard class.
// Depends on hhc_pkg and hsv_hsl_color_converter_top.
`timescale 1ns / 100ps

module tb_top;
    import hhc_pkg::*;

    localparam int CB = 16;
    localparam longint FS = (64'd1 << CB) - 1;
    localparam longint TURN = 64'd1 << CB;
    localparam int LATENCY = CB + 7;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [15:0] c0;
        logic [15:0] c1;
        logic [15:0] c2;
        logic [15:0] alpha;
    } pixel_t;

    // Expected-pixel store with the conversion predictor
    class pixel_scoreboard;
        pixel_t pending[$];
        conv_mode_t mode;
        int errors;
        int checked;

        function new();
            mode = MODE_RGB2HSV;
            errors = 0;
            checked = 0;
        endfunction

        static function longint rdiv(longint n, longint d);
            return (d != 0) ? (n + d / 2) / d : 0;
        endfunction

        static function longint clampfs(longint v);
            return (v > FS) ? FS : v;
        endfunction

        static function longint hue_of(longint r, longint g, longint b, longint mx, longint ch);
            longint num;
            longint h;
            if (mx == r) num = g - b;
            else if (mx == g) num = 2 * ch + b - r;
            else num = 4 * ch + r - g;
            if (num < 0) num += 6 * ch;
            h = rdiv(num << CB, 6 * ch);
            if (h >= TURN) h -= TURN;
            return h;
        endfunction

        // place chroma on the hue hexagon
        static function void hexagon(longint h, longint ch, output longint r, output longint g,
                                     output longint b);
            longint t, sec, frac, x;
            t = h * 6;
            sec = t >> CB;
            frac = t & (TURN - 1);
            x = sec[0] ? rdiv(ch * (TURN - frac), TURN) : rdiv(ch * frac, TURN);
            case (sec)
                0: begin r = ch; g = x; b = 0; end
                1: begin r = x; g = ch; b = 0; end
                2: begin r = 0; g = ch; b = x; end
                3: begin r = 0; g = x; b = ch; end
                4: begin r = x; g = 0; b = ch; end
                default: begin r = ch; g = 0; b = x; end
            endcase
        endfunction

        static function pixel_t convert(conv_mode_t md, pixel_t p);
            longint c0, c1, c2, mx, mn, ch, sum, den, l2, base, d;
            longint o[3];
            longint cp[3];
            pixel_t q;
            c0 = p.c0; c1 = p.c1; c2 = p.c2;
            o = '{0, 0, 0};
            if (md == MODE_RGB2HSV || md == MODE_RGB2HSL) begin
                mx = (c0 > c1) ? c0 : c1;
                if (c2 > mx) mx = c2;
                mn = (c0 < c1) ? c0 : c1;
                if (c2 < mn) mn = c2;
                ch = mx - mn;
                if (ch != 0) o[0] = hue_of(c0, c1, c2, mx, ch);
                if (md == MODE_RGB2HSV) begin
                    if (mx != 0) o[1] = clampfs(rdiv(ch * FS, mx));
                    o[2] = mx;
                end else begin
                    sum = mx + mn;
                    if (ch != 0) begin
                        den = (sum <= FS) ? sum : (2 * FS - sum);
                        o[1] = clampfs(rdiv(ch * FS, den));
                    end
                    o[2] = clampfs((sum + 1) >> 1);
                end
            end else if (md == MODE_HSV2RGB) begin
                ch = rdiv(c2 * c1, FS);
                if (ch > c2) ch = c2;
                hexagon(c0, ch, cp[0], cp[1], cp[2]);
                for (int i = 0; i < 3; i++) o[i] = clampfs(cp[i] + (c2 - ch));
            end else begin
                l2 = 2 * c2;
                base = (l2 <= FS) ? l2 : (2 * FS - l2);
                ch = rdiv(base * c1, FS);
                if (ch > base) ch = base;
                hexagon(c0, ch, cp[0], cp[1], cp[2]);
                for (int i = 0; i < 3; i++) begin
                    d = 2 * cp[i] + l2 - ch;
                    o[i] = clampfs((d + 1) >> 1);
                end
            end
            q.c0 = o[0][15:0];
            q.c1 = o[1][15:0];
            q.c2 = o[2][15:0];
            q.alpha = p.alpha;
            return q;
        endfunction

        function void note_request(pixel_t p);
            pending.push_back(convert(mode, p));
        endfunction

        function void check_result(pixel_t got);
            pixel_t exp;
            if (pending.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
                return;
            end
            exp = pending.pop_front();
            checked++;
            if (got.c0 !== exp.c0) begin
                $error("out_c0 expected %0d actual %0d", exp.c0, got.c0); errors++;
            end
            if (got.c1 !== exp.c1) begin
                $error("out_c1 expected %0d actual %0d", exp.c1, got.c1); errors++;
            end
            if (got.c2 !== exp.c2) begin
                $error("out_c2 expected %0d actual %0d", exp.c2, got.c2); errors++;
            end
            if (got.alpha !== exp.alpha) begin
                $error("out_alpha expected %0d actual %0d", exp.alpha, got.alpha); errors++;
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    pixel_t s_pix = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    pixel_t m_pix;

    pixel_scoreboard sb;
    longint cycles = 0;
    bit src_idle_en = 1'b1;
    bit sink_idle_en = 1'b1;
    int hold_off = 0;
    int stall_req = 0;
    int stall_seen = 0;
    int sent = 0;

    always #1 aclk = ~aclk;

    hsv_hsl_color_converter_top #(.CHANNEL_BITS(CB)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_in_c0(s_pix.c0), .s_in_c1(s_pix.c1), .s_in_c2(s_pix.c2), .s_in_alpha(s_pix.alpha),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_c0(m_pix.c0), .m_out_c1(m_pix.c1), .m_out_c2(m_pix.c2),
        .m_out_alpha(m_pix.alpha)
    );

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side: random stall bursts, plus a long hold-off on request
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_pix);
        if (stall_req != stall_seen) begin
            stall_seen <= stall_req;
            hold_off <= 200;
            m_ready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 1'b0;
        end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
            hold_off <= $urandom_range(1, 19);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // valid stays up between back-to-back requests; dropped only when idling or draining
    task automatic send_pixel(pixel_t p);
        s_valid <= 1'b1;
        s_pix <= p;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(p);
        sent++;
        if (src_idle_en && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic set_mode(conv_mode_t md);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= md;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.mode = md;
    endtask

    function automatic logic [15:0] rnd_chan();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'(($urandom_range(0, 1) == 1) ? 16'h8000 : 16'h7FFF);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic pixel_t rnd_pixel();
        pixel_t p;
        p.c0 = rnd_chan();
        p.c1 = rnd_chan();
        p.c2 = rnd_chan();
        p.alpha = 16'($urandom);
        // grey and tie cases now and then
        if ($urandom_range(0, 9) == 0) p.c1 = p.c0;
        if ($urandom_range(0, 9) == 0) p.c2 = p.c0;
        return p;
    endfunction

    initial begin
        conv_mode_t modes[4];
        sb = new();
        modes = '{MODE_RGB2HSV, MODE_HSV2RGB, MODE_RGB2HSL, MODE_HSL2RGB};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed corners in every mode: black, white, grey, primaries, ties, hue wrap
        foreach (modes[k]) begin
            set_mode(modes[k]);
            send_pixel('{16'h0000, 16'h0000, 16'h0000, 16'h0000});
            send_pixel('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
            send_pixel('{16'h8000, 16'h8000, 16'h8000, 16'h1234});
            send_pixel('{16'hFFFF, 16'h0000, 16'h0000, 16'h0001});
            send_pixel('{16'h0000, 16'hFFFF, 16'h0000, 16'h0002});
            send_pixel('{16'h0000, 16'h0000, 16'hFFFF, 16'h0003});
            send_pixel('{16'hFFFF, 16'hFFFF, 16'h0000, 16'h0004});
            send_pixel('{16'hFFFF, 16'h0000, 16'h0001, 16'h0005});
            send_pixel('{16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h0006});
        end

        // Random pixels across modes, extremes included
        for (int ph = 0; ph < 8; ph++) begin
            set_mode(modes[$urandom_range(0, 3)]);
            if (ph == 3) begin
                // long receiver stall while the sender keeps pushing
                stall_req = stall_req + 1;
            end
            for (int n = 0; n < 70; n++) send_pixel(rnd_pixel());
            if (ph == 5) drain();
        end

        // Final stretch with no idling on either side
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        set_mode(MODE_HSL2RGB);
        for (int n = 0; n < 40; n++) send_pixel(rnd_pixel());
        set_mode(MODE_RGB2HSV);
        for (int n = 0; n < 20; n++) send_pixel(rnd_pixel());
        drain();

        $display("Sent %0d pixels over all four conversion modes, %0d results checked.",
                 sent, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/hhc_pkg.sv
rtl/core/hhc_front.sv
rtl/core/hhc_div.sv
rtl/core/hhc_back.sv
rtl/core/hsv_hsl_color_converter_top.sv
rtl/core/hhc_checker.sv
sim/tb_top.sv
